// File: hdl/calu_pkg.sv
// package: shared widths and beat types for the cascaded four-bit function alu
`timescale 1ns / 1ps

package calu_pkg;

   localparam int DATA_W   = 32;
   localparam int NIB_W    = 4;
   localparam int SEL_W    = 4;
   localparam int NIBBLES  = DATA_W / NIB_W;

   // one item as it moves down the slice pipeline
   typedef struct packed {
      logic [DATA_W-1:0] operand_a;
      logic [DATA_W-1:0] operand_b;
      logic              mode;
      logic [SEL_W-1:0]  action;
      logic              carry;
      logic [DATA_W-1:0] result;
      logic              all_equal;
      logic              group_propagate;
      logic              group_generate;
   } beat_type;

   // outputs of one four-bit slice
   typedef struct packed {
      logic [NIB_W-1:0] f;
      logic             cout;
      logic             eq;
      logic             p;
      logic             g;
   } slice_out_type;

endpackage

// File: hdl/calu_req_if.sv
// interface: request channel carrying operands, carry-in, mode and function select
`timescale 1ns / 1ps

interface calu_req_if;
   import calu_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] operand_a;
   logic [DATA_W-1:0] operand_b;
   logic              carry_in;
   logic              mode;
   logic [SEL_W-1:0]  action;

   modport source (output valid, operand_a, operand_b, carry_in, mode, action, input ready);
   modport sink   (input valid, operand_a, operand_b, carry_in, mode, action, output ready);
endinterface

// File: hdl/calu_rsp_if.sv
// interface: response channel carrying the result word and flags
`timescale 1ns / 1ps

interface calu_rsp_if;
   import calu_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] result;
   logic              carry_out;
   logic              all_equal;
   logic              group_propagate;
   logic              group_generate;

   modport source (output valid, result, carry_out, all_equal, group_propagate,
                   group_generate, input ready);
   modport sink   (input valid, result, carry_out, all_equal, group_propagate,
                   group_generate, output ready);
endinterface

// File: hdl/calu_slice.sv
// module: gate-level four-bit function slice with inverted carries
`timescale 1ns / 1ps

module calu_slice (
   input  logic                              cn,
   input  logic                              m,
   input  logic [calu_pkg::NIB_W-1:0]        a,
   input  logic [calu_pkg::NIB_W-1:0]        b,
   input  logic [calu_pkg::SEL_W-1:0]        s,
   output calu_pkg::slice_out_type           res
);
   import calu_pkg::*;

   logic [NIB_W-1:0] x;
   logic [NIB_W-1:0] y;
   logic             nm;
   logic             c1, c2, c3;
   logic [NIB_W-1:0] f;
   logic             gsum;

   // upper and lower terms per bit
   always_comb begin
      for (int i = 0; i < NIB_W; i++) begin
         x[i] = ~(a[i] | (b[i] & s[0]) | (s[1] & ~b[i]));
         y[i] = ~((~b[i] & s[2] & a[i]) | (a[i] & b[i] & s[3]));
      end
   end

   assign nm = ~m;

   // internal carries, inverted
   assign c1 = ~((nm & x[0]) | (nm & y[0] & cn));
   assign c2 = ~((nm & x[1]) | (nm & x[0] & y[1]) | (nm & cn & y[0] & y[1]));
   assign c3 = ~((nm & x[2]) | (nm & x[1] & y[2]) | (nm & x[0] & y[1] & y[2])
                 | (nm & cn & y[0] & y[1] & y[2]));

   assign f[0] = ~(cn & nm) ^ (~x[0] & y[0]);
   assign f[1] = c1 ^ (~x[1] & y[1]);
   assign f[2] = c2 ^ (~x[2] & y[2]);
   assign f[3] = c3 ^ (~x[3] & y[3]);

   assign gsum = (x[0] & y[1] & y[2] & y[3]) | (x[1] & y[2] & y[3])
               | (x[2] & y[3]) | x[3];

   assign res.f    = f;
   assign res.eq   = &f;
   assign res.p    = ~(&y);
   assign res.g    = ~gsum;
   assign res.cout = (cn & (&y)) | gsum;

endmodule

// File: hdl/calu_stage.sv
// module: one pipeline stage that applies slice INDEX and registers the beat
`timescale 1ns / 1ps

module calu_stage #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  calu_pkg::beat_type in_beat,
   output logic               out_valid,
   input  logic               out_ready,
   output calu_pkg::beat_type out_beat
);
   import calu_pkg::*;

   localparam int LO     = INDEX * NIB_W;
   // result position kept inside the word for slices above the operand width
   localparam int LO_RES = (INDEX < NIBBLES) ? LO : 0;

   logic [NIB_W-1:0] nib_a;
   logic [NIB_W-1:0] nib_b;
   slice_out_type    sres;
   beat_type         beat_in;
   beat_type         beat_ff;
   logic             valid_ff;

   // slices above the operand width see zero operand bits
   generate
      if (INDEX < NIBBLES) begin : g_data
         assign nib_a = in_beat.operand_a[LO +: NIB_W];
         assign nib_b = in_beat.operand_b[LO +: NIB_W];
      end else begin : g_zero
         assign nib_a = '0;
         assign nib_b = '0;
      end
   endgenerate

   calu_slice u_slice (
      .cn  (in_beat.carry),
      .m   (in_beat.mode),
      .a   (nib_a),
      .b   (nib_b),
      .s   (in_beat.action),
      .res (sres)
   );

   always_comb begin
      beat_in                 = in_beat;
      beat_in.carry           = sres.cout;
      beat_in.all_equal       = in_beat.all_equal & sres.eq;
      beat_in.group_propagate = sres.p;
      beat_in.group_generate  = sres.g;
      if (INDEX < NIBBLES) begin
         beat_in.result[LO_RES +: NIB_W] = sres.f;
      end
   end

   assign in_ready = ~valid_ff | out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

// File: hdl/calu_skid.sv
// module: output register with skid entry so the request side sees a registered ready
`timescale 1ns / 1ps

module calu_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  calu_pkg::beat_type in_beat,
   output logic               out_valid,
   input  logic               out_ready,
   output calu_pkg::beat_type out_beat
);
   import calu_pkg::*;

   logic     out_valid_ff;
   logic     skid_valid_ff;
   beat_type out_beat_ff;
   beat_type skid_beat_ff;

   assign in_ready = ~skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (~out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff  <= in_valid;
         end
      end else if (in_valid && in_ready) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (~out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_beat_ff <= skid_beat_ff;
         end else if (in_valid) begin
            out_beat_ff <= in_beat;
         end
      end else if (in_valid && in_ready) begin
         skid_beat_ff <= in_beat;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_beat  = out_beat_ff;

endmodule

// File: hdl/cascaded_four_bit_function_alu.sv
// top level: cascaded four-bit function alu, one slice per pipeline stage
`timescale 1ns / 1ps
//
// usage
//   req_bus carries two operand words, an inverted carry-in, the mode bit
//   (1 = logic, 0 = arithmetic) and the 4-bit function select. rsp_bus returns
//   the result word, the inverted carry-out, the all-ones flag and the top
//   slice's propagate and generate. a beat moves when valid and ready are high.
// throughput and path
//   one beat per clock while rsp_bus ready is high. a beat passes through each of
//   SLICES slice stages in turn, then sits in the output register before it
//   appears on rsp_bus; the carry ripple through the slices sets the stage count.
// reset
//   synchronous; clears all stage valid bits and the output buffer. req_bus
//   ready is high in the first cycle after reset.
// stalls
//   when rsp_bus ready is low, the stages fill up and hold their beats; the
//   skid entry at the output keeps req_bus ready off a combinational path
//   from rsp_bus ready. nothing is lost or repeated.
//
module cascaded_four_bit_function_alu #(
   parameter int SLICES = 8
) (
   input  logic              clock,
   input  logic              reset,
   calu_req_if.sink          req_bus,
   calu_rsp_if.source        rsp_bus
);
   import calu_pkg::*;

   beat_type               head_beat;
   beat_type               stage_beat  [SLICES];
   logic     [SLICES-1:0]  stage_valid;
   logic     [SLICES:0]    stage_ready;
   beat_type               rsp_beat;

   // beat entering slice 0: result empty, equality flag primed
   always_comb begin
      head_beat                 = '0;
      head_beat.operand_a       = req_bus.operand_a;
      head_beat.operand_b       = req_bus.operand_b;
      head_beat.mode            = req_bus.mode;
      head_beat.action          = req_bus.action;
      head_beat.carry           = req_bus.carry_in;
      head_beat.all_equal       = 1'b1;
   end

   assign req_bus.ready = stage_ready[0];

   // carry ripples from one stage to the next together with the beat
   generate
      for (genvar k = 0; k < SLICES; k++) begin : g_stage
         if (k == 0) begin : g_first
            calu_stage #(.INDEX(k)) u_stage (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (req_bus.valid),
               .in_ready  (stage_ready[k]),
               .in_beat   (head_beat),
               .out_valid (stage_valid[k]),
               .out_ready (stage_ready[k+1]),
               .out_beat  (stage_beat[k])
            );
         end else begin : g_next
            calu_stage #(.INDEX(k)) u_stage (
               .clock     (clock),
               .reset     (reset),
               .in_valid  (stage_valid[k-1]),
               .in_ready  (stage_ready[k]),
               .in_beat   (stage_beat[k-1]),
               .out_valid (stage_valid[k]),
               .out_ready (stage_ready[k+1]),
               .out_beat  (stage_beat[k])
            );
         end
      end
   endgenerate

   // output register plus skid entry
   calu_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[SLICES-1]),
      .in_ready  (stage_ready[SLICES]),
      .in_beat   (stage_beat[SLICES-1]),
      .out_valid (rsp_bus.valid),
      .out_ready (rsp_bus.ready),
      .out_beat  (rsp_beat)
   );

   assign rsp_bus.result          = rsp_beat.result;
   assign rsp_bus.carry_out       = rsp_beat.carry;
   assign rsp_bus.all_equal       = rsp_beat.all_equal;
   assign rsp_bus.group_propagate = rsp_beat.group_propagate;
   assign rsp_bus.group_generate  = rsp_beat.group_generate;

endmodule

// File: hdl/calu_checker.sv
// checker: port-level assertions for the cascaded four-bit function alu, with bind
`timescale 1ns / 1ps

module calu_checker #(
   parameter int SLICES = 8
) (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [calu_pkg::DATA_W-1:0] rsp_result,
   input logic                        rsp_carry_out,
   input logic                        rsp_all_equal
);
   import calu_pkg::*;

   localparam int LIVE_NIBBLES = (SLICES < NIBBLES) ? SLICES : NIBBLES;
   localparam logic [DATA_W-1:0] LIVE_MASK =
      (LIVE_NIBBLES == NIBBLES) ? {DATA_W{1'b1}} :
      ((DATA_W'(1) << (LIVE_NIBBLES * NIB_W)) - DATA_W'(1));

   // response held while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
                                  && $stable(rsp_carry_out))
      else $error("response dropped or changed under stall");

   // reset leaves an empty pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_ready)
      else $error("request side not ready after reset");

   // equality flag implies every live result bit is set
   a_equal_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_all_equal |-> ((rsp_result & LIVE_MASK) == LIVE_MASK))
      else $error("all_equal set with a zero result bit");

endmodule

bind cascaded_four_bit_function_alu calu_checker #(.SLICES(SLICES)) u_calu_checker (
   .clock         (clock),
   .reset         (reset),
   .req_ready     (req_bus.ready),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_result    (rsp_bus.result),
   .rsp_carry_out (rsp_bus.carry_out),
   .rsp_all_equal (rsp_bus.all_equal)
);
